@@ hdl/m3inv_pkg.sv @@
// Shared types, widths and constants for the 3x3 inverse and solve block.
`default_nettype none
package m3inv_pkg;
  localparam int InWidth  = 16;
  localparam int FracBits = 8;
  localparam int OutFrac  = 16;
  localparam int DetW     = 3 * InWidth + 2;
  localparam int MagW     = DetW;
  localparam int QW       = 32;
  localparam int NumW     = MagW + OutFrac + FracBits;
  localparam int StepW    = $clog2(NumW + 1);
  localparam int InBits   = 12 * InWidth;
  localparam int InBytes  = (InBits + 7) / 8;
  localparam int OutBits  = 2 + 4 * QW + DetW + 1;
  localparam int OutBytes = (OutBits + 7) / 8;
  localparam int QDepth   = 2;
  localparam logic signed [QW-1:0] MinusOne = -32'sd65536;
  localparam logic [QW-1:0] PosLim = 32'h7FFF_FFFF;
  localparam logic [QW-1:0] NegLim = 32'h8000_0000;

  typedef logic signed [InWidth-1:0] elem_t;
  typedef logic signed [DetW-1:0] det_t;

  typedef struct packed {
    det_t [2:0][2:0] cof;
    det_t [2:0]      cram;
    det_t            det;
  } job_t;

  typedef struct packed {
    logic [1:0]            row;
    logic signed [QW-1:0]  c0;
    logic signed [QW-1:0]  c1;
    logic signed [QW-1:0]  c2;
    logic signed [QW-1:0]  x;
    det_t                  det;
    logic                  sing;
    logic                  last;
  } res_t;

  typedef enum logic [1:0] {DIdle, DLoad, DRun, DDone} div_e;
endpackage
`default_nettype wire

@@ hdl/m3inv_front.sv @@
// Front stage: determinant, cofactor and Cramer numerators in a registered pipeline.
`default_nettype none
module m3inv_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  output logic                             ready_o,
  input  wire logic [m3inv_pkg::InBits-1:0] data_i,
  output logic                             valid_o,
  input  wire logic                        ready_i,
  output m3inv_pkg::job_t                  job_o
);
  m3inv_pkg::elem_t a_q [3][3];
  m3inv_pkg::elem_t b_q [3];
  m3inv_pkg::det_t  cof_q [3][3];
  m3inv_pkg::det_t  ccof_q [3][3];
  m3inv_pkg::det_t  cof1_q [3][3];
  m3inv_pkg::elem_t a1_q [3][3];
  m3inv_pkg::elem_t b1_q [3];
  m3inv_pkg::det_t  pd_q [3];
  m3inv_pkg::det_t  pc_q [3][3];
  logic [3:0] v_q;
  logic adv;

  assign adv     = !v_q[3] || ready_i;
  assign ready_o = adv;
  assign valid_o = v_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          a_q[r][c] <= data_i[(r*3+c)*m3inv_pkg::InWidth +: m3inv_pkg::InWidth];
        end
        b_q[r] <= data_i[(9+r)*m3inv_pkg::InWidth +: m3inv_pkg::InWidth];
      end
      // Signed cofactors and the 2x2 minors needed for the replaced columns.
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          cof_q[r][c] <= m3inv_pkg::DetW'(a_q[(r+1)%3][(c+1)%3] * a_q[(r+2)%3][(c+2)%3])
                       - m3inv_pkg::DetW'(a_q[(r+1)%3][(c+2)%3] * a_q[(r+2)%3][(c+1)%3]);
          ccof_q[r][c] <= m3inv_pkg::DetW'(a_q[(r+1)%3][(c+1)%3] * a_q[(r+2)%3][(c+2)%3])
                        - m3inv_pkg::DetW'(a_q[(r+1)%3][(c+2)%3] * a_q[(r+2)%3][(c+1)%3]);
        end
      end
      a1_q <= a_q;
      b1_q <= b_q;
      cof1_q <= cof_q;
      for (int r = 0; r < 3; r++) begin
        pd_q[r] <= m3inv_pkg::DetW'(a1_q[r][0] * cof_q[r][0]);
        for (int k = 0; k < 3; k++) begin
          pc_q[k][r] <= m3inv_pkg::DetW'(b1_q[r] * ccof_q[r][k]);
        end
      end
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          job_o.cof[r][c] <= cof1_q[c][r];
        end
      end
      job_o.det <= pd_q[0] + pd_q[1] + pd_q[2];
      for (int k = 0; k < 3; k++) begin
        job_o.cram[k] <= pc_q[k][0] + pc_q[k][1] + pc_q[k][2];
      end
    end
  end
endmodule
`default_nettype wire

@@ hdl/m3inv_queue.sv @@
// Two-entry request queue between the front and back stages.
`default_nettype none
module m3inv_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire m3inv_pkg::job_t   data_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output m3inv_pkg::job_t        data_o
);
  m3inv_pkg::job_t mem_q [m3inv_pkg::QDepth];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;

  assign ready_o = cnt_q != 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rp_q];
  assign wr = valid_i && ready_o;
  assign rd = valid_o && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= data_i;
  end

`ifndef SYNTHESIS
  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overflow");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i && !wr |=> valid_o && $stable(data_o))
    else $error("queue head changed while stalled");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr && !rd |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("queue count wrong");
`endif
endmodule
`default_nettype wire

@@ hdl/m3inv_div.sv @@
// Serial restoring divider for scaled quotients, truncated and saturated to 32 bits.
`default_nettype none
module m3inv_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire m3inv_pkg::det_t              num_i,
  input  wire m3inv_pkg::det_t              den_i,
  input  wire logic                         wide_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic signed [m3inv_pkg::QW-1:0]   q_o
);
  localparam int NW = m3inv_pkg::NumW;
  m3inv_pkg::div_e st_q, st_d;
  logic [NW-1:0] n_q;
  logic [m3inv_pkg::MagW:0] r_q, d_q, rs;
  logic [NW:0] acc_q;
  logic [m3inv_pkg::StepW-1:0] cnt_q;
  logic neg_q;
  logic [m3inv_pkg::QW-1:0] lim;
  m3inv_pkg::det_t nm, dm;

  assign nm = num_i[m3inv_pkg::DetW-1] ? -num_i : num_i;
  assign dm = den_i[m3inv_pkg::DetW-1] ? -den_i : den_i;
  assign rs = {r_q[m3inv_pkg::MagW-1:0], n_q[NW-1]};
  assign lim = neg_q ? m3inv_pkg::NegLim : m3inv_pkg::PosLim;
  assign busy_o = st_q != m3inv_pkg::DIdle;
  assign done_o = st_q == m3inv_pkg::DDone;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      m3inv_pkg::DIdle: if (start_i) st_d = m3inv_pkg::DRun;
      m3inv_pkg::DLoad: st_d = m3inv_pkg::DRun;
      m3inv_pkg::DRun:  if (cnt_q == '0) st_d = m3inv_pkg::DDone;
      m3inv_pkg::DDone: st_d = m3inv_pkg::DIdle;
      default:          st_d = m3inv_pkg::DIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= m3inv_pkg::DIdle;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    if (st_q == m3inv_pkg::DIdle && start_i) begin
      // Numerator is the magnitude shifted left by the output scale.
      n_q <= wide_i ? NW'(nm) << (m3inv_pkg::OutFrac + m3inv_pkg::FracBits)
                    : NW'(nm) << (m3inv_pkg::OutFrac + m3inv_pkg::FracBits);
      if (!wide_i) n_q <= NW'(nm) << m3inv_pkg::OutFrac;
      d_q <= {1'b0, dm};
      r_q <= '0;
      acc_q <= '0;
      neg_q <= num_i[m3inv_pkg::DetW-1] ^ den_i[m3inv_pkg::DetW-1];
      cnt_q <= m3inv_pkg::StepW'(NW - 1);
    end else if (st_q == m3inv_pkg::DRun) begin
      n_q <= n_q << 1;
      cnt_q <= cnt_q - 1'b1;
      if (rs >= d_q) begin
        r_q <= rs - d_q;
        acc_q <= {acc_q[NW-1:0], 1'b1};
      end else begin
        r_q <= rs;
        acc_q <= {acc_q[NW-1:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (acc_q > (NW+1)'(lim)) q_o = neg_q ? -lim : lim;
    else q_o = neg_q ? -acc_q[m3inv_pkg::QW-1:0] : acc_q[m3inv_pkg::QW-1:0];
  end
endmodule
`default_nettype wire

@@ hdl/m3inv_back.sv @@
// Back stage: four dividers per row, then one result register toward the output.
`default_nettype none
module m3inv_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire m3inv_pkg::job_t    job_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output m3inv_pkg::res_t         res_o
);
  logic [1:0] row_q;
  logic run_q, outv_q, sing, start;
  logic [3:0] busy, done;
  logic signed [m3inv_pkg::QW-1:0] q [4];
  m3inv_pkg::det_t num [4];
  logic [1:0] rrow_q;
  logic fin;

  assign sing = job_i.det == '0;
  assign start = valid_i && !run_q && !sing && !outv_q;
  assign num[0] = job_i.cof[row_q][0];
  assign num[1] = job_i.cof[row_q][1];
  assign num[2] = job_i.cof[row_q][2];
  assign num[3] = job_i.cram[row_q];

  for (genvar g = 0; g < 4; g++) begin : g_div
    m3inv_div u_div (
      .clk_i, .rst_ni, .start_i(start), .num_i(num[g]), .den_i(job_i.det),
      .wide_i(g != 3), .busy_o(busy[g]), .done_o(done[g]), .q_o(q[g]));
  end

  assign valid_o = outv_q;
  assign fin = (done[0] || (valid_i && sing && !outv_q));
  assign ready_o = fin && row_q == 2'd2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      run_q <= 1'b0;
      outv_q <= 1'b0;
    end else begin
      if (outv_q && ready_i) outv_q <= 1'b0;
      if (start) run_q <= 1'b1;
      if (fin) begin
        run_q <= 1'b0;
        outv_q <= 1'b1;
        row_q <= row_q == 2'd2 ? 2'd0 : row_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      res_o.row  <= row_q;
      res_o.c0   <= sing ? m3inv_pkg::MinusOne : q[0];
      res_o.c1   <= sing ? m3inv_pkg::MinusOne : q[1];
      res_o.c2   <= sing ? m3inv_pkg::MinusOne : q[2];
      res_o.x    <= sing ? m3inv_pkg::MinusOne : q[3];
      res_o.det  <= job_i.det;
      res_o.sing <= sing;
      res_o.last <= row_q == 2'd2;
      rrow_q <= row_q;
    end
  end

`ifndef SYNTHESIS
  a_row: assert property (@(posedge clk_i) disable iff (!rst_ni) row_q != 2'd3)
    else $error("row counter out of range");
  a_lock: assert property (@(posedge clk_i) disable iff (!rst_ni) busy[0] == busy[3])
    else $error("dividers out of step");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outv_q |-> res_o.last == (rrow_q == 2'd2))
    else $error("last flag mismatch");
`endif
endmodule
`default_nettype wire

@@ hdl/matrix3_inverse_cramer_solve.sv @@
// Top level of the 3x3 matrix inverse and Cramer solve block.
//  Channel | Dir | Request
//  s_axis  | in  | a00..a22, b0..b2, 16 bits each
//  m_axis  | out | one row result, tlast on row 2
// The front pipeline takes one matrix per cycle unless the queue stalls its output; each
// job passes the input, cofactor, product and job registers before it reaches the queue.
// Each row runs four parallel serial dividers; a singular matrix skips the dividers.
// Reset clears all control state; no clearing pass is needed.
// Either side may stall without losing a request.
`default_nettype none
module matrix3_inverse_cramer_solve (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // a00,a01,a02,a10,a11,a12,a20,a21,a22,b0,b1,b2 from bit 0 up
  input  wire logic [m3inv_pkg::InBytes*8-1:0]     s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // row_index,inv_col0,inv_col1,inv_col2,solution,determinant,singular from bit 0 up
  output logic [m3inv_pkg::OutBytes*8-1:0]         m_axis_tdata,
  output logic                                     m_axis_tlast
);
  logic fv, fr, qv, qr;
  m3inv_pkg::job_t fj, qj;
  m3inv_pkg::res_t r;

  m3inv_front u_front (.clk_i, .rst_ni, .valid_i(s_axis_tvalid), .ready_o(s_axis_tready),
    .data_i(s_axis_tdata[m3inv_pkg::InBits-1:0]), .valid_o(fv), .ready_i(fr), .job_o(fj));
  m3inv_queue u_queue (.clk_i, .rst_ni, .valid_i(fv), .ready_o(fr), .data_i(fj),
    .valid_o(qv), .ready_i(qr), .data_o(qj));
  m3inv_back u_back (.clk_i, .rst_ni, .valid_i(qv), .ready_o(qr), .job_i(qj),
    .valid_o(m_axis_tvalid), .ready_i(m_axis_tready), .res_o(r));

  assign m_axis_tdata = (m3inv_pkg::OutBytes*8)'({r.sing, r.det, r.x, r.c2, r.c1, r.c0,
                                                  r.row});
  assign m_axis_tlast = r.last;
endmodule
`default_nettype wire

@@ sim/tb_matrix3_inverse_cramer_solve.sv @@
// Testbench for the 3x3 matrix inverse and Cramer solve block.
`timescale 1ns / 1ps
`default_nettype none
module tb_matrix3_inverse_cramer_solve;

  typedef m3inv_pkg::elem_t [11:0] mat_req_t;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  // a00,a01,a02,a10,a11,a12,a20,a21,a22,b0,b1,b2 from bit 0 up
  logic [m3inv_pkg::InBytes*8-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  // row_index,inv_col0,inv_col1,inv_col2,solution,determinant,singular from bit 0 up
  logic [m3inv_pkg::OutBytes*8-1:0] m_axis_tdata;
  logic m_axis_tlast;

  m3inv_pkg::res_t pending_rows[$];
  int   err_count = 0;
  bit   idling = 1'b1;
  int   hold_left = 0;

  matrix3_inverse_cramer_solve i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("tb_matrix3_inverse_cramer_solve: errors");
    $finish;
  end

  function automatic longint det3(input longint m [9]);
    return m[0] * (m[4] * m[8] - m[5] * m[7])
         - m[1] * (m[3] * m[8] - m[5] * m[6])
         + m[2] * (m[3] * m[7] - m[4] * m[6]);
  endfunction

  // Scaled quotient, truncated toward zero and clamped to 32 bits.
  function automatic logic signed [m3inv_pkg::QW-1:0] sat_quot(input longint num,
                                                               input longint den,
                                                               input int sh);
    bit neg;
    longint unsigned n, d, q, r, lim;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    q = n / d;
    r = n % d;
    if (q > lim) begin
      q = lim;
    end else begin
      for (int i = 0; i < sh; i++) begin
        q = q << 1;
        r = r << 1;
        if (r >= d) begin
          r = r - d;
          q = q + 1;
        end
        if (q > lim) begin
          q = lim;
          break;
        end
      end
    end
    return neg ? -q : q;
  endfunction

  task automatic predict_rows(input mat_req_t req);
    longint m [9];
    longint t [9];
    longint vb [3];
    longint cof [3][3];
    longint det;
    logic signed [m3inv_pkg::QW-1:0] xs [3];
    m3inv_pkg::res_t row;
    for (int k = 0; k < 9; k++) m[k] = longint'(req[k]);
    for (int k = 0; k < 3; k++) vb[k] = longint'(req[9 + k]);
    det = det3(m);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        cof[r][c] = m[((r + 1) % 3) * 3 + (c + 1) % 3] * m[((r + 2) % 3) * 3 + (c + 2) % 3]
                  - m[((r + 1) % 3) * 3 + (c + 2) % 3] * m[((r + 2) % 3) * 3 + (c + 1) % 3];
    for (int k = 0; k < 3; k++) begin
      t = m;
      for (int r = 0; r < 3; r++) t[r * 3 + k] = vb[r];
      xs[k] = (det == 0) ? m3inv_pkg::MinusOne : sat_quot(det3(t), det, m3inv_pkg::OutFrac);
    end
    for (int r = 0; r < 3; r++) begin
      row.row  = r[1:0];
      row.c0   = (det == 0) ? m3inv_pkg::MinusOne
                            : sat_quot(cof[0][r], det, m3inv_pkg::OutFrac + m3inv_pkg::FracBits);
      row.c1   = (det == 0) ? m3inv_pkg::MinusOne
                            : sat_quot(cof[1][r], det, m3inv_pkg::OutFrac + m3inv_pkg::FracBits);
      row.c2   = (det == 0) ? m3inv_pkg::MinusOne
                            : sat_quot(cof[2][r], det, m3inv_pkg::OutFrac + m3inv_pkg::FracBits);
      row.x    = xs[r];
      row.det  = det[m3inv_pkg::DetW-1:0];
      row.sing = (det == 0);
      row.last = (r == 2);
      pending_rows.push_back(row);
    end
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  task automatic check_row();
    m3inv_pkg::res_t want;
    if (pending_rows.size() == 0) begin
      report("unexpected result", m_axis_tdata[63:0], '0);
    end else begin
      want = pending_rows.pop_front();
      if (m_axis_tdata[1:0] !== want.row) report("row_index", m_axis_tdata[1:0], want.row);
      if (m_axis_tdata[33:2] !== want.c0) report("inv_col0", m_axis_tdata[33:2], want.c0);
      if (m_axis_tdata[65:34] !== want.c1) report("inv_col1", m_axis_tdata[65:34], want.c1);
      if (m_axis_tdata[97:66] !== want.c2) report("inv_col2", m_axis_tdata[97:66], want.c2);
      if (m_axis_tdata[129:98] !== want.x) report("solution", m_axis_tdata[129:98], want.x);
      if (m_axis_tdata[179:130] !== want.det)
        report("determinant", m_axis_tdata[179:130], want.det);
      if (m_axis_tdata[180] !== want.sing) report("singular", m_axis_tdata[180], want.sing);
      if (m_axis_tlast !== want.last) report("tlast", m_axis_tlast, want.last);
    end
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        check_row();
        stall_left = idling ? $urandom_range(0, 16) : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_mat(input mat_req_t req);
    int gap;
    gap = idling ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_rows(req);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
  endtask

  function automatic mat_req_t build_mat(input m3inv_pkg::elem_t v [12]);
    mat_req_t req;
    for (int k = 0; k < 12; k++) req[k] = v[k];
    return req;
  endfunction

  function automatic m3inv_pkg::elem_t pick_extreme();
    case ($urandom_range(0, 7))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      3: return 16'sd256;
      4: return -16'sd256;
      5: return 16'sd1;
      6: return -16'sd1;
      default: return m3inv_pkg::elem_t'($urandom);
    endcase
  endfunction

  function automatic mat_req_t random_mat(input int kind);
    mat_req_t req;
    int src;
    for (int k = 0; k < 12; k++) begin
      case (kind)
        0: req[k] = m3inv_pkg::elem_t'($urandom);
        1: req[k] = m3inv_pkg::elem_t'($urandom_range(0, 2047)) - 16'sd1024;
        2: req[k] = (k < 9 && k % 4 == 0) ? m3inv_pkg::elem_t'($urandom_range(512, 32767))
                                          : m3inv_pkg::elem_t'($urandom_range(0, 511))
                                            - 16'sd256;
        3: req[k] = m3inv_pkg::elem_t'($urandom);
        default: req[k] = pick_extreme();
      endcase
    end
    // Rank-deficient matrix: copy one row onto another, or zero a column.
    if (kind == 3) begin
      if ($urandom_range(0, 1)) begin
        src = $urandom_range(0, 1) * 3;
        for (int c = 0; c < 3; c++) req[6 + c] = req[src + c];
      end else begin
        for (int r = 0; r < 3; r++) req[r * 3 + 1] = '0;
      end
    end
    return req;
  endfunction

  task automatic test_directed();
    send_mat(build_mat('{256, 0, 0, 0, 256, 0, 0, 0, 256, 256, -512, 768}));
    send_mat(build_mat('{0, 0, 0, 0, 0, 0, 0, 0, 0, 100, 200, 300}));
    send_mat(build_mat('{-32768, -32768, -32768, -32768, -32768, -32768,
                         -32768, -32768, -32768, -32768, -32768, -32768}));
    send_mat(build_mat('{32767, 0, 0, 0, 32767, 0, 0, 0, 32767, 32767, 32767, 32767}));
    send_mat(build_mat('{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768, 32767, -32768, 1}));
    // A unit determinant with extreme right-hand sides drives the solutions to the 32-bit limits.
    send_mat(build_mat('{1, 0, 0, 0, 1, 0, 0, 0, 1, 32767, -32768, 1}));
    send_mat(build_mat('{-1, 0, 0, 0, 1, 0, 0, 0, 1, -32768, 32767, 0}));
    send_mat(build_mat('{0, 256, 0, 0, 0, 256, 256, 0, 0, 512, -256, 1}));
    send_mat(build_mat('{512, 256, 0, 256, 512, 256, 0, 256, 512, 256, 256, 256}));
    send_mat(build_mat('{256, 512, 768, 512, 1024, 1536, 1, 2, 3, 1, 2, 3}));
    send_mat(build_mat('{32767, -32768, 32767, -32768, 32767, -32768,
                         32767, 32767, -32768, -1, 0, 32767}));
    send_mat(build_mat('{-300, 17, 900, 4, -2560, 33, 1000, -7, 5, -1, 1, 0}));
    send_mat(build_mat('{3, 0, 0, 0, 256, 0, 0, 0, 256, -32768, 0, 0}));
    send_mat(build_mat('{32767, 32767, 0, 32767, -32768, 0, 0, 0, 1, 0, 0, 1}));
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_left = 600;
    for (int i = 0; i < 8; i++) send_mat(random_mat(2));
    wait_drained();
  endtask

  task automatic test_random(input int count, input bit with_idle);
    int sel;
    idling = with_idle;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 9);
      send_mat(random_mat(sel < 3 ? 1 : sel < 6 ? 2 : sel < 7 ? 0 : sel < 8 ? 3 : 4));
    end
    wait_drained();
    idling = 1'b1;
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(300, 1'b1);
    test_random(80, 1'b0);
    repeat (300) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_matrix3_inverse_cramer_solve: clean");
    end else begin
      $display("tb_matrix3_inverse_cramer_solve: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
hdl/m3inv_pkg.sv
hdl/m3inv_front.sv
hdl/m3inv_queue.sv
hdl/m3inv_div.sv
hdl/m3inv_back.sv
hdl/matrix3_inverse_cramer_solve.sv
sim/tb_matrix3_inverse_cramer_solve.sv
